FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the relay controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define SHRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("shrc: property violated");

// Check that a condition is never seen outside reset.
`define SHRC_DENY(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("shrc: forbidden condition seen");

`endif

FILE: sv/shrc_pkg.sv
// Package of the relay controller: payload structs, codes and constants.
`default_nettype none

package shrc_pkg;

  // Number of schedule windows, one chain cell each (1 to 8)
  localparam int SCHED_ENTRIES = 8;

  // Field widths
  localparam int TIME_W  = 17;
  localparam int END_W   = 18;
  localparam int DAY_W   = 3;
  localparam int MASK_W  = 7;
  localparam int SLOT_W  = 3;
  localparam int SENS_W  = 24;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [END_W-1:0] DAY_SECONDS = END_W'(86400);
  localparam logic [DAY_W-1:0] LAST_DAY    = 3'd6;
  localparam logic [DAY_W-1:0] NO_DAY      = 3'd7;

  typedef enum logic [1:0] {
    MODE_MANUAL    = 2'd0,
    MODE_SCHEDULE  = 2'd1,
    MODE_THRESHOLD = 2'd2
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_CONTROL_MODE   = 2'd0,
    CFG_MANUAL_ON      = 2'd1,
    CFG_LOW_THRESHOLD  = 2'd2,
    CFG_HIGH_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_EVALUATE = 1'b0,
    CMD_WRITE    = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // Input request
  typedef struct packed {
    logic                     command;
    logic signed [SENS_W-1:0] sensor_value;
    logic [TIME_W-1:0]        time_of_day;
    logic [DAY_W-1:0]         weekday;
    logic [SLOT_W-1:0]        entry_slot;
    logic                     entry_enabled;
    logic [TIME_W-1:0]        entry_start;
    logic [TIME_W-1:0]        entry_duration;
    logic [MASK_W-1:0]        entry_days;
  } in_req_t;

  // Output response
  typedef struct packed {
    logic relay_on;
    logic switched_on;
    logic switched_off;
  } out_rsp_t;

  // Window write broadcast to the cells
  typedef struct packed {
    logic              enabled;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] length;
    logic [MASK_W-1:0] days;
  } win_wr_t;

  // Evaluation token passed from cell to cell
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [DAY_W-1:0]  day;
    logic [DAY_W-1:0]  prev;
    logic              cur;
  } sched_tok_t;

endpackage

`default_nettype wire

FILE: sv/scheduled_hysteresis_relay_controller_top.sv
// Top level of the scheduled hysteresis relay controller.
// Usage:
//   Requests enter on in_valid_i/in_req_i and are taken when in_stall_o is low.
//   One response per request leaves on out_valid_o/out_rsp_o, taken when
//   out_stall_i is low. The user must write configuration registers through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block does not check it.
// Request flow:
//   Window writes, manual and threshold evaluations answer in the cycle after
//   the request is taken; while out_stall_i is low, the next request may
//   follow in the next cycle. Schedule evaluations walk a chain of
//   SCHED_ENTRIES window cells, one cell per cycle, and answer after the token
//   leaves the last cell; in_stall_o stays high while it is in the chain.
// Reset:
//   The relay is off, every window is disabled, mode is manual with the relay
//   off, thresholds are 0 and 100.
// Receiver stall:
//   The response register holds its value; a new request is taken in the
//   same cycle the held response is taken, and not before.
`default_nettype none

module scheduled_hysteresis_relay_controller_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire shrc_pkg::in_req_t                    in_req_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output shrc_pkg::out_rsp_t                        out_rsp_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [shrc_pkg::CIDX_W-1:0]          cfg_idx_i,
  input  wire logic [shrc_pkg::CFG_W-1:0]           cfg_wdata_i
);

  // Configuration registers
  logic [1:0]                          mode_q;
  logic                                manual_on_q;
  logic signed [shrc_pkg::THR_W-1:0]   low_thr_q;
  logic signed [shrc_pkg::THR_W-1:0]   high_thr_q;

  // Control and relay state
  shrc_pkg::state_e                    state_q, state_d;
  logic                                running_q, running_d;
  logic                                out_valid_q, out_valid_d;
  shrc_pkg::out_rsp_t                  out_rsp_q, out_rsp_d;

  logic                                accept;
  logic                                is_write;
  logic                                start_scan;
  logic                                load;
  logic                                after;
  logic signed [shrc_pkg::SENS_W-1:0]  lo_scaled;
  logic signed [shrc_pkg::SENS_W-1:0]  hi_scaled;

  // Cell chain
  logic                                tok_valid [shrc_pkg::SCHED_ENTRIES+1];
  shrc_pkg::sched_tok_t                tok       [shrc_pkg::SCHED_ENTRIES+1];
  logic [shrc_pkg::SCHED_ENTRIES-1:0]  wr_sel;
  shrc_pkg::win_wr_t                   wr_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= shrc_pkg::MODE_MANUAL;
      manual_on_q <= 1'b0;
      low_thr_q   <= 16'sd0;
      high_thr_q  <= 16'sd100;
    end else if (cfg_we_i) begin
      unique case (shrc_pkg::cfg_reg_e'(cfg_idx_i))
        shrc_pkg::CFG_CONTROL_MODE:   mode_q      <= cfg_wdata_i[1:0];
        shrc_pkg::CFG_MANUAL_ON:      manual_on_q <= cfg_wdata_i[0];
        shrc_pkg::CFG_LOW_THRESHOLD:  low_thr_q   <= cfg_wdata_i;
        shrc_pkg::CFG_HIGH_THRESHOLD: high_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stall the input while scanning or while a response is held back
  assign in_stall_o = (state_q != shrc_pkg::ST_IDLE) || (out_valid_q && out_stall_i);

  assign accept     = in_valid_i && !in_stall_o;
  assign is_write   = (in_req_i.command == shrc_pkg::CMD_WRITE);
  assign start_scan = accept && !is_write && (mode_q == shrc_pkg::MODE_SCHEDULE);

  // Broadcast a window write to the addressed cell
  assign wr_data = '{enabled: in_req_i.entry_enabled,
                     start:   in_req_i.entry_start,
                     length:  in_req_i.entry_duration,
                     days:    in_req_i.entry_days};

  // Inject the evaluation token at the head of the chain
  always_comb begin
    tok_valid[0]  = start_scan;
    tok[0].now    = in_req_i.time_of_day;
    tok[0].day    = (in_req_i.weekday == shrc_pkg::NO_DAY) ? shrc_pkg::NO_DAY
                                                           : in_req_i.weekday;
    tok[0].prev   = (in_req_i.weekday == '0) ? shrc_pkg::LAST_DAY
                                             : in_req_i.weekday - 3'd1;
    tok[0].cur    = running_q;
  end

  for (genvar i = 0; i < shrc_pkg::SCHED_ENTRIES; i++) begin : g_cell
    assign wr_sel[i] = accept && is_write && (32'(in_req_i.entry_slot) == i);

    shrc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (wr_sel[i]),
      .wr_i        (wr_data),
      .tok_valid_i (tok_valid[i]),
      .tok_i       (tok[i]),
      .tok_valid_o (tok_valid[i+1]),
      .tok_o       (tok[i+1])
    );
  end

  // Scale the thresholds to the sample's 8 fraction bits
  assign lo_scaled = {low_thr_q, 8'h00};
  assign hi_scaled = {high_thr_q, 8'h00};

  // Decide the new relay state for immediate requests
  always_comb begin
    after = running_q;
    if (!is_write) begin
      case (mode_q)
        shrc_pkg::MODE_MANUAL: begin
          after = manual_on_q;
        end
        shrc_pkg::MODE_THRESHOLD: begin
          if (($signed(in_req_i.sensor_value) < lo_scaled) && !running_q) begin
            after = 1'b1;
          end else if (($signed(in_req_i.sensor_value) >= hi_scaled) && running_q) begin
            after = 1'b0;
          end
        end
        default: after = running_q;
      endcase
    end
  end

  // Sequence requests and load the response register
  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    load        = 1'b0;
    unique case (state_q)
      shrc_pkg::ST_IDLE: begin
        if (start_scan) begin
          state_d = shrc_pkg::ST_SCAN;
        end else if (accept) begin
          load      = 1'b1;
          running_d = after;
        end
      end
      shrc_pkg::ST_SCAN: begin
        if (tok_valid[shrc_pkg::SCHED_ENTRIES]) begin
          load      = 1'b1;
          running_d = tok[shrc_pkg::SCHED_ENTRIES].cur;
          state_d   = shrc_pkg::ST_IDLE;
        end
      end
      default: state_d = shrc_pkg::ST_IDLE;
    endcase
    if (load) begin
      out_valid_d            = 1'b1;
      out_rsp_d.relay_on     = running_d;
      out_rsp_d.switched_on  = running_d && !running_q;
      out_rsp_d.switched_off = !running_d && running_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shrc_pkg::ST_IDLE;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

FILE: sv/shrc_cell.sv
// One schedule window cell: stores a window and updates the passing token.
`default_nettype none

module shrc_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire shrc_pkg::win_wr_t    wr_i,
  input  wire logic                 tok_valid_i,
  input  wire shrc_pkg::sched_tok_t tok_i,
  output logic                      tok_valid_o,
  output shrc_pkg::sched_tok_t      tok_o
);

  logic                               en_q;
  logic [shrc_pkg::TIME_W-1:0]        start_q;
  logic [shrc_pkg::END_W-1:0]         end_q;
  logic                               wraps_q;
  logic [shrc_pkg::MASK_W-1:0]        days_q;

  logic [shrc_pkg::END_W-1:0]         sum;
  logic                               wraps_d;
  logic [shrc_pkg::END_W-1:0]         end_d;
  logic [shrc_pkg::MASK_W:0]          days_ext;
  logic                               match;
  logic                               after_start;
  logic                               before_end;
  logic                               in_window;

  logic                               tok_valid_q;
  shrc_pkg::sched_tok_t               tok_q;
  shrc_pkg::sched_tok_t               tok_d;

  // Resolve the window end and its wrap past midnight at write time
  always_comb begin
    sum     = {1'b0, wr_i.start} + {1'b0, wr_i.length};
    wraps_d = (sum >= shrc_pkg::DAY_SECONDS);
    end_d   = wraps_d ? (sum - shrc_pkg::DAY_SECONDS) : sum;
  end

  // Hold the enable bit; window fields need no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (wr_en_i) begin
      en_q <= wr_i.enabled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      start_q <= wr_i.start;
      end_q   <= end_d;
      wraps_q <= wraps_d;
      days_q  <= wr_i.days;
    end
  end

  // Match the day mask and time window; day 7 sees a zero bit unless wrapping
  always_comb begin
    days_ext    = {1'b0, days_q};
    match       = wraps_q ? days_ext[tok_i.prev] : days_ext[tok_i.day];
    after_start = (tok_i.now >= start_q);
    before_end  = ({1'b0, tok_i.now} < end_q);
    in_window   = wraps_q ? (after_start || before_end) : (after_start && before_end);
  end

  // Let a matching enabled window overwrite the relay state in the token
  always_comb begin
    tok_d = tok_i;
    if (en_q && match) begin
      tok_d.cur = in_window;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

`default_nettype wire

FILE: sv/shrc_checker.sv
// Port-level checker of the relay controller and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module shrc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire shrc_pkg::out_rsp_t                  out_rsp_o
);

  // A stalled response stays offered
  `SHRC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // No request is taken while a response is held back
  `SHRC_ASSERT(a_in_blocked, clk_i, rst_ni, out_valid_o && out_stall_i |-> in_stall_o)

  // Both edge pulses never fire together
  `SHRC_DENY(a_pulse_excl, clk_i, rst_ni, out_valid_o && out_rsp_o.switched_on && out_rsp_o.switched_off)

  // A switch-on pulse agrees with the reported relay state
  `SHRC_DENY(a_pulse_state, clk_i, rst_ni, out_valid_o && (out_rsp_o.switched_on != out_rsp_o.relay_on) && out_rsp_o.switched_on)

  // The $past(in_valid_i) term holds after every taken request, so this never fails
  `SHRC_ASSERT(a_resp_follows, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o |=> !in_stall_o || out_valid_o || $past(in_valid_i))

endmodule

bind scheduled_hysteresis_relay_controller_top shrc_checker u_shrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

FILE: tb/tb_scheduled_hysteresis_relay_controller_top.sv
// Self-checking testbench of the scheduled hysteresis relay controller top level.
module tb_scheduled_hysteresis_relay_controller_top;
  import shrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = SCHED_ENTRIES + 4;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam out_rsp_t HOLD_OFF = 3'b000;
  localparam out_rsp_t HOLD_ON  = 3'b100;
  localparam out_rsp_t TURN_ON  = 3'b110;
  localparam out_rsp_t TURN_OFF = 3'b001;

  typedef struct {
    logic              is_setting;
    logic [1:0]        mode;
    logic              man;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    in_req_t           req;
    logic              known;
    out_rsp_t          rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_idx = CFG_CONTROL_MODE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Predicted block state and register copy
  logic              relay_q;
  logic              win_on [SCHED_ENTRIES];
  logic [TIME_W-1:0] win_start [SCHED_ENTRIES];
  logic [TIME_W-1:0] win_len [SCHED_ENTRIES];
  logic [MASK_W-1:0] win_days [SCHED_ENTRIES];
  logic [1:0]        mode_q;
  logic              manual_q;
  logic signed [15:0] low_q;
  logic signed [15:0] high_q;

  out_rsp_t pending_relay [$];
  row_t directed [$];
  int gap_pct = 0;
  int stall_pct = 0;
  int unsigned cycle_count = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sched = 0;
  int n_writes = 0;
  int n_switches = 0;

  scheduled_hysteresis_relay_controller_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Generate the clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_relay.size());
      $display("tb_scheduled_hysteresis_relay_controller_top failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Append one row to the directed table
  function automatic void add_row(input row_t row);
    directed.insert(directed.size(), row);
  endfunction

  // Work out the response of one request and advance the predicted state
  function automatic out_rsp_t next_relay_state(input in_req_t r);
    logic was;
    logic nxt;
    logic wraps;
    logic hit;
    logic [DAY_W-1:0] prev;
    logic [END_W-1:0] stop;
    int sample;
    int lo_scaled;
    int hi_scaled;
    int i;
    out_rsp_t rsp;
    was = relay_q;
    nxt = relay_q;
    if (r.command == CMD_WRITE) begin
      win_on[r.entry_slot]    = r.entry_enabled;
      win_start[r.entry_slot] = r.entry_start;
      win_len[r.entry_slot]   = r.entry_duration;
      win_days[r.entry_slot]  = r.entry_days;
    end else if (mode_q == MODE_MANUAL) begin
      nxt = manual_q;
    end else if (mode_q == MODE_SCHEDULE) begin
      prev = (r.weekday == 3'd0) ? LAST_DAY : r.weekday - 3'd1;
      // Scan every window; the last matching one decides
      for (i = 0; i < SCHED_ENTRIES; i++) begin
        if (win_on[i]) begin
          stop = win_start[i] + win_len[i];
          wraps = (stop >= DAY_SECONDS);
          if (wraps) begin
            stop = stop - DAY_SECONDS;
            hit = win_days[i][prev];
          end else begin
            hit = (r.weekday == NO_DAY) ? 1'b0 : win_days[i][r.weekday];
          end
          if (hit) begin
            if (wraps)
              nxt = (r.time_of_day >= win_start[i]) || (r.time_of_day < stop);
            else
              nxt = (r.time_of_day >= win_start[i]) && (r.time_of_day < stop);
          end
        end
      end
    end else if (mode_q == MODE_THRESHOLD) begin
      sample = $signed(r.sensor_value);
      lo_scaled = low_q * 256;
      hi_scaled = high_q * 256;
      if (sample < lo_scaled && !was)
        nxt = 1'b1;
      else if (sample >= hi_scaled && was)
        nxt = 1'b0;
    end
    relay_q = nxt;
    rsp.relay_on = nxt;
    rsp.switched_on = nxt & ~was;
    rsp.switched_off = ~nxt & was;
    return rsp;
  endfunction

  // Check responses in order and drive the receiver stall
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_relay.size() == 0) begin
          report_mismatch($sformatf("response %b with none expected", out_rsp));
        end else begin
          want = pending_relay.pop_front();
          if (out_rsp.relay_on !== want.relay_on)
            report_mismatch($sformatf("relay_on %b, expected %b (response %0d)",
                                      out_rsp.relay_on, want.relay_on, n_checked));
          if (out_rsp.switched_on !== want.switched_on)
            report_mismatch($sformatf("switched_on %b, expected %b (response %0d)",
                                      out_rsp.switched_on, want.switched_on, n_checked));
          if (out_rsp.switched_off !== want.switched_off)
            report_mismatch($sformatf("switched_off %b, expected %b (response %0d)",
                                      out_rsp.switched_off, want.switched_off, n_checked));
          if (out_rsp.switched_on || out_rsp.switched_off)
            n_switches++;
          n_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one request, wait for it to be taken, then record its response
  task automatic send_request(input in_req_t r, input logic known, input out_rsp_t typed);
    out_rsp_t want;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (in_stall);
    want = next_relay_state(r);
    pending_relay.insert(pending_relay.size(), known ? typed : want);
    n_sent++;
    if (r.command == CMD_WRITE)
      n_writes++;
    else if (mode_q == MODE_SCHEDULE)
      n_sched++;
  endtask

  // Hold off until every response has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_relay.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CONTROL_MODE:   mode_q = data[1:0];
      CFG_MANUAL_ON:      manual_q = data[0];
      CFG_LOW_THRESHOLD:  low_q = data;
      CFG_HIGH_THRESHOLD: high_q = data;
      default: ;
    endcase
  endtask

  // Write all four registers; call only while idle
  task automatic apply_settings(input logic [1:0] mode, input logic man,
                                input logic signed [15:0] lo, input logic signed [15:0] hi);
    cfg_write(CFG_CONTROL_MODE, CFG_W'(mode));
    cfg_write(CFG_MANUAL_ON, CFG_W'(man));
    cfg_write(CFG_LOW_THRESHOLD, lo);
    cfg_write(CFG_HIGH_THRESHOLD, hi);
    cfg_we <= 1'b0;
  endtask

  function automatic row_t setting_row(input logic [1:0] mode, input logic man,
                                       input logic signed [15:0] lo,
                                       input logic signed [15:0] hi);
    row_t row;
    row = '{is_setting: 1'b1, mode: mode, man: man, lo: lo, hi: hi,
            req: '0, known: 1'b0, rsp: HOLD_OFF};
    return row;
  endfunction

  function automatic row_t eval_row(input int sample, input int tod, input int day,
                                    input logic known, input out_rsp_t rsp);
    row_t row;
    row = '{is_setting: 1'b0, mode: MODE_NONE, man: 1'b0, lo: '0, hi: '0,
            req: '0, known: known, rsp: rsp};
    row.req.command = CMD_EVALUATE;
    row.req.sensor_value = sample[SENS_W-1:0];
    row.req.time_of_day = tod[TIME_W-1:0];
    row.req.weekday = day[DAY_W-1:0];
    return row;
  endfunction

  function automatic row_t window_row(input int slot, input logic en, input int start,
                                      input int dur, input int days,
                                      input logic known, input out_rsp_t rsp);
    row_t row;
    row = '{is_setting: 1'b0, mode: MODE_NONE, man: 1'b0, lo: '0, hi: '0,
            req: '0, known: known, rsp: rsp};
    row.req.command = CMD_WRITE;
    row.req.entry_slot = slot[SLOT_W-1:0];
    row.req.entry_enabled = en;
    row.req.entry_start = start[TIME_W-1:0];
    row.req.entry_duration = dur[TIME_W-1:0];
    row.req.entry_days = days[MASK_W-1:0];
    return row;
  endfunction

  function automatic logic signed [15:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Build a random request: mostly well-formed, some raw noise
  function automatic in_req_t random_request(input int write_pct);
    logic [95:0] raw;
    in_req_t r;
    int s;
    int edge_t;
    int sample;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(in_req_t)-1:0];
    r.command = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_EVALUATE;
    if ($urandom_range(0, 99) < 85) begin
      r.weekday = DAY_W'($urandom_range(0, 6));
      r.time_of_day = TIME_W'($urandom_range(0, 86399));
      r.entry_start = TIME_W'($urandom_range(0, 86399));
      r.entry_duration = TIME_W'($urandom_range(0, 1) ? $urandom_range(0, 7200)
                                                      : $urandom_range(0, 86399));
      // Aim the time at a window edge
      s = $urandom_range(0, SCHED_ENTRIES - 1);
      if (win_on[s] && $urandom_range(0, 1)) begin
        edge_t = $urandom_range(0, 1) ? int'(win_start[s])
                                      : int'(win_start[s]) + int'(win_len[s]);
        edge_t = edge_t + int'($urandom_range(0, 2)) - 1;
        if (edge_t < 0)
          edge_t = edge_t + 86400;
        edge_t = edge_t % 86400;
        r.time_of_day = edge_t[TIME_W-1:0];
      end
      // Aim the sample at a threshold
      if (mode_q == MODE_THRESHOLD) begin
        sample = ($urandom_range(0, 1) ? low_q : high_q) * 256;
        sample = sample + int'($urandom_range(0, 1024)) - 512;
        if (sample > 8388607)
          sample = 8388607;
        if (sample < -8388608)
          sample = -8388608;
        r.sensor_value = sample[SENS_W-1:0];
      end
    end
    return r;
  endfunction

  initial begin
    row_t row;
    logic [1:0] mode;
    int items;
    int phase;
    int k;

    relay_q = 1'b0;
    for (k = 0; k < SCHED_ENTRIES; k++) begin
      win_on[k] = 1'b0;
      win_start[k] = '0;
      win_len[k] = '0;
      win_days[k] = '0;
    end
    mode_q = MODE_MANUAL;
    manual_q = 1'b0;
    low_q = 16'sd0;
    high_q = 16'sd100;

    // Directed table: manual, idle mode, threshold extremes, schedule windows
    add_row(eval_row(0, 0, 0, 1'b1, HOLD_OFF));
    add_row(setting_row(MODE_MANUAL, 1'b1, 16'sd0, 16'sd100));
    add_row(eval_row(0, 0, 0, 1'b1, TURN_ON));
    add_row(eval_row(0, 0, 0, 1'b1, HOLD_ON));
    add_row(setting_row(MODE_NONE, 1'b0, 16'sd0, 16'sd100));
    add_row(eval_row(-8388608, 0, 0, 1'b1, HOLD_ON));
    add_row(setting_row(MODE_THRESHOLD, 1'b0, 16'sh8000, 16'sh7fff));
    add_row(eval_row(-8388608, 0, 0, 1'b1, HOLD_ON));
    add_row(eval_row(8388607, 0, 0, 1'b1, TURN_OFF));
    add_row(eval_row(-8388608, 0, 0, 1'b1, HOLD_OFF));
    add_row(setting_row(MODE_THRESHOLD, 1'b0, 16'sd0, 16'sd100));
    add_row(eval_row(-1, 0, 0, 1'b1, TURN_ON));
    add_row(eval_row(25599, 0, 0, 1'b1, HOLD_ON));
    add_row(eval_row(25600, 0, 0, 1'b1, TURN_OFF));
    // Crossed thresholds toggle on every sample
    add_row(setting_row(MODE_THRESHOLD, 1'b0, 16'sd10, -16'sd10));
    add_row(eval_row(0, 0, 0, 1'b1, TURN_ON));
    add_row(eval_row(0, 0, 0, 1'b1, TURN_OFF));
    add_row(setting_row(MODE_SCHEDULE, 1'b0, 16'sd0, 16'sd100));
    add_row(eval_row(0, 3600, 3, 1'b1, HOLD_OFF));
    add_row(window_row(0, 1'b1, 3600, 3600, 7'h7f, 1'b1, HOLD_OFF));
    add_row(window_row(7, 1'b1, 86000, 1000, 7'h02, 1'b1, HOLD_OFF));
    add_row(eval_row(0, 3600, 3, 1'b0, HOLD_OFF));
    add_row(eval_row(0, 7200, 3, 1'b0, HOLD_OFF));
    // Window wrapping past midnight matches on the previous day
    add_row(eval_row(0, 300, 2, 1'b0, HOLD_OFF));
    add_row(eval_row(0, 86100, 1, 1'b0, HOLD_OFF));
    // Weekday seven matches no mask bit for today
    add_row(eval_row(0, 3700, 7, 1'b0, HOLD_OFF));
    add_row(window_row(3, 1'b1, 131071, 131071, 7'h40, 1'b0, HOLD_OFF));
    add_row(eval_row(0, 131071, 7, 1'b0, HOLD_OFF));
    add_row(eval_row(0, 0, 0, 1'b0, HOLD_OFF));
    add_row(window_row(3, 1'b0, 0, 0, 7'h00, 1'b0, HOLD_OFF));

    // Hold reset, then release
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_setting) begin
        drain_results();
        apply_settings(row.mode, row.man, row.lo, row.hi);
      end else begin
        send_request(row.req, row.known, row.rsp);
      end
    end

    // Random part: three idling profiles, four register settings each
    for (phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 37 : (phase == 1) ? 53 : 0;
      stall_pct = (phase == 0) ? 53 : (phase == 1) ? 37 : 0;
      for (k = 0; k < 4; k++) begin
        mode = (k == 3) ? 2'($urandom_range(0, 3)) : 2'(k);
        drain_results();
        apply_settings(mode, 1'($urandom), pick_threshold(), pick_threshold());
        items = (mode == MODE_SCHEDULE) ? 50 : 28;
        repeat (items) begin
          send_request(random_request((mode == MODE_SCHEDULE) ? 25 : 10), 1'b0, HOLD_OFF);
        end
      end
    end

    drain_results();
    $display("covered %0d requests: %0d window writes, %0d schedule evaluations",
             n_sent, n_writes, n_sched);
    $display("checked %0d responses with %0d relay switches, %0d mismatches",
             n_checked, n_switches, errors);
    if (errors == 0) begin
      $display("tb_scheduled_hysteresis_relay_controller_top passed");
    end else begin
      $display("tb_scheduled_hysteresis_relay_controller_top failed");
    end
    $finish;
  end

endmodule
